@@ src/spf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the scaled pixel frame store.
// No dependencies; imported by every module of the block.
package spf_pkg;

  localparam int MaxWidthDefault  = 64;
  localparam int MaxHeightDefault = 32;

  // Command queue between the front and back parts
  localparam int FifoDepth = 2;

  // Physical coordinates, wide enough for a doubled position plus an origin
  localparam int CoordW = 9;
  localparam int ColorW = 16;

  // Action codes of an input word
  localparam logic [2:0] ACT_DRAW       = 3'd0;
  localparam logic [2:0] ACT_DRAW_AT    = 3'd1;
  localparam logic [2:0] ACT_CLEAR_ALL  = 3'd2;
  localparam logic [2:0] ACT_CLEAR_RECT = 3'd3;
  localparam logic [2:0] ACT_READ       = 3'd4;
  localparam logic [2:0] ACT_SET_FLAG   = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_PANEL_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_PANEL_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PIXEL_SCALE  = 2'd2;
  localparam logic [1:0] CFG_BACKGROUND   = 2'd3;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_DRAW,
    KIND_CLEAR_ALL,
    KIND_CLEAR_RECT,
    KIND_READ,
    KIND_FLAG
  } cmd_kind_e;

  // Classified command: x0/y0 is the pixel or rectangle corner, x1/y1 the
  // exclusive rectangle end.
  typedef struct packed {
    cmd_kind_e         kind;
    logic              dbl;
    logic              oor;
    logic              flag;
    logic [ColorW-1:0] color;
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
  } cmd_t;

  typedef struct packed {
    logic [ColorW-1:0] read_color;
    logic              modified;
    logic              oor;
  } result_t;

endpackage

@@ src/spf_front.sv @@
`timescale 1ns / 1ps
// Front part: configuration registers and classification of input words.
// Depends on spf_pkg.
module spf_front #(
  parameter int MAX_WIDTH  = spf_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT = spf_pkg::MaxHeightDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [15:0]                cfg_wdata_i,
  input  logic [2:0]                 action_i,
  input  logic [5:0]                 pos_x_i,
  input  logic [4:0]                 pos_y_i,
  input  logic [5:0]                 origin_x_i,
  input  logic [4:0]                 origin_y_i,
  input  logic [6:0]                 rect_width_i,
  input  logic [5:0]                 rect_height_i,
  input  logic [spf_pkg::ColorW-1:0] pixel_color_i,
  input  logic                       flag_value_i,
  output spf_pkg::cmd_t              cmd_o,
  output logic [spf_pkg::ColorW-1:0] bg_color_o
);
  import spf_pkg::*;

  localparam logic [CoordW-1:0] MaxW = CoordW'(MAX_WIDTH);
  localparam logic [CoordW-1:0] MaxH = CoordW'(MAX_HEIGHT);

  logic [6:0]        panel_width_q;
  logic [5:0]        panel_height_q;
  logic [1:0]        pixel_scale_q;
  logic [ColorW-1:0] bg_color_q;

  logic [CoordW-1:0] w_eff, h_eff, pw_ext, ph_ext;
  logic              dbl;
  logic [CoordW-1:0] size, px, py, xe, ye;
  logic              draw_oor, read_in, rect_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_width_q  <= 7'd64;
      panel_height_q <= 6'd32;
      pixel_scale_q  <= 2'd1;
      bg_color_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PANEL_WIDTH:  panel_width_q  <= cfg_wdata_i[6:0];
        CFG_PANEL_HEIGHT: panel_height_q <= cfg_wdata_i[5:0];
        CFG_PIXEL_SCALE:  pixel_scale_q  <= cfg_wdata_i[1:0];
        CFG_BACKGROUND:   bg_color_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign bg_color_o = bg_color_q;

  always_comb begin
    // clamp the panel to 1..MAX on each axis
    pw_ext = CoordW'(panel_width_q);
    ph_ext = CoordW'(panel_height_q);
    if (panel_width_q == '0)  w_eff = CoordW'(1);
    else if (pw_ext > MaxW)   w_eff = MaxW;
    else                      w_eff = pw_ext;
    if (panel_height_q == '0) h_eff = CoordW'(1);
    else if (ph_ext > MaxH)   h_eff = MaxH;
    else                      h_eff = ph_ext;

    dbl  = (pixel_scale_q == 2'd2);
    size = dbl ? CoordW'(2) : CoordW'(1);
    px   = dbl ? CoordW'({pos_x_i, 1'b0}) : CoordW'(pos_x_i);
    py   = dbl ? CoordW'({pos_y_i, 1'b0}) : CoordW'(pos_y_i);
    if (action_i == ACT_DRAW_AT) begin
      px = px + CoordW'(origin_x_i);
      py = py + CoordW'(origin_y_i);
    end
    draw_oor = (px + size > w_eff) || (py + size > h_eff);
    read_in  = (CoordW'(pos_x_i) < w_eff) && (CoordW'(pos_y_i) < h_eff);

    // clip the rectangle to the panel
    xe = CoordW'(origin_x_i) + CoordW'(rect_width_i);
    ye = CoordW'(origin_y_i) + CoordW'(rect_height_i);
    if (xe > w_eff) xe = w_eff;
    if (ye > h_eff) ye = h_eff;
    rect_empty = (CoordW'(origin_x_i) >= xe) || (CoordW'(origin_y_i) >= ye);

    cmd_o       = '0;
    cmd_o.kind  = KIND_NOP;
    cmd_o.dbl   = dbl;
    cmd_o.color = pixel_color_i;
    case (action_i)
      ACT_DRAW, ACT_DRAW_AT: begin
        if (draw_oor) begin
          cmd_o.oor = 1'b1;
        end else begin
          cmd_o.kind = KIND_DRAW;
          cmd_o.x0   = px;
          cmd_o.y0   = py;
        end
      end
      ACT_CLEAR_ALL: cmd_o.kind = KIND_CLEAR_ALL;
      ACT_CLEAR_RECT: begin
        if (rect_empty) begin
          // nothing to write, but the flag still gets set
          cmd_o.kind = KIND_FLAG;
          cmd_o.flag = 1'b1;
        end else begin
          cmd_o.kind = KIND_CLEAR_RECT;
          cmd_o.x0   = CoordW'(origin_x_i);
          cmd_o.y0   = CoordW'(origin_y_i);
          cmd_o.x1   = xe;
          cmd_o.y1   = ye;
        end
      end
      ACT_READ: begin
        if (read_in) begin
          cmd_o.kind = KIND_READ;
          cmd_o.x0   = CoordW'(pos_x_i);
          cmd_o.y0   = CoordW'(pos_y_i);
        end else begin
          cmd_o.oor = 1'b1;
        end
      end
      ACT_SET_FLAG: begin
        cmd_o.kind = KIND_FLAG;
        cmd_o.flag = flag_value_i;
      end
      default: ;
    endcase
  end

endmodule

@@ src/spf_cmd_fifo.sv @@
`timescale 1ns / 1ps
// Short command queue between the front and back parts.
// Depends on spf_pkg for the command type and depth.
module spf_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  spf_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output spf_pkg::cmd_t head_o,
  output logic          empty_o,
  output logic          full_o
);
  import spf_pkg::*;

  localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW = $clog2(FifoDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(FifoDepth - 1);

  cmd_t            entry_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(FifoDepth));
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ src/spf_back.sv @@
`timescale 1ns / 1ps
// Back part: executes queued commands against the single-port pixel store.
// Depends on spf_pkg.
module spf_back #(
  parameter int MAX_WIDTH  = spf_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT = spf_pkg::MaxHeightDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  spf_pkg::cmd_t              cmd_i,
  input  logic [spf_pkg::ColorW-1:0] bg_color_i,
  output logic                       cmd_pop_o,
  output logic                       init_busy_o,
  output logic                       done_o,
  output spf_pkg::result_t           result_o
);
  import spf_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam logic [AW-1:0] RowStep  = AW'(MAX_WIDTH);
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DRAW,
    ST_READ,
    ST_FILL,
    ST_RECT
  } state_e;

  state_e            state_q;
  logic [AW-1:0]     ptr_q, row_q;
  logic [1:0]        step_q;
  logic              dbl_q;
  logic [ColorW-1:0] color_q;
  logic [CoordW-1:0] cx_q, cy_q, x0_q, x1_q, y1_q;
  logic              flag_q;
  logic              done_q;
  result_t           result_q;

  logic [ColorW-1:0] mem [Depth];
  logic [ColorW-1:0] rd_q;

  logic [AW-1:0]     head_row, head_addr, draw_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [ColorW-1:0] mem_wdata;

  assign init_busy_o = (state_q == ST_INIT);
  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;
  assign done_o      = done_q;
  assign result_o    = result_q;

  always_comb begin
    head_row  = AW'(AW'(cmd_i.y0) * RowStep);
    head_addr = head_row + AW'(cmd_i.x0);
    case (step_q)
      2'd0:    draw_addr = ptr_q;
      2'd1:    draw_addr = ptr_q + AW'(1);
      2'd2:    draw_addr = ptr_q + RowStep;
      default: draw_addr = ptr_q + RowStep + AW'(1);
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = ptr_q;
    mem_wdata = bg_color_i;
    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      ST_FILL: mem_we = 1'b1;
      ST_DRAW: begin
        mem_we    = 1'b1;
        mem_addr  = draw_addr;
        mem_wdata = color_q;
      end
      ST_RECT: begin
        mem_we   = 1'b1;
        mem_addr = row_q + AW'(cx_q);
      end
      ST_IDLE: mem_addr = head_addr;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      ptr_q    <= '0;
      row_q    <= '0;
      step_q   <= '0;
      dbl_q    <= 1'b0;
      color_q  <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      x0_q     <= '0;
      x1_q     <= '0;
      y1_q     <= '0;
      flag_q   <= 1'b1;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_INIT: begin
          // zero the whole store once after reset
          ptr_q <= ptr_q + AW'(1);
          if (ptr_q == LastAddr) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.kind)
              KIND_DRAW: begin
                ptr_q   <= head_addr;
                step_q  <= '0;
                dbl_q   <= cmd_i.dbl;
                color_q <= cmd_i.color;
                state_q <= ST_DRAW;
              end
              KIND_READ: state_q <= ST_READ;
              KIND_CLEAR_ALL: begin
                ptr_q   <= '0;
                state_q <= ST_FILL;
              end
              KIND_CLEAR_RECT: begin
                cx_q    <= cmd_i.x0;
                x0_q    <= cmd_i.x0;
                x1_q    <= cmd_i.x1;
                cy_q    <= cmd_i.y0;
                y1_q    <= cmd_i.y1;
                row_q   <= head_row;
                state_q <= ST_RECT;
              end
              KIND_FLAG: begin
                flag_q   <= cmd_i.flag;
                done_q   <= 1'b1;
                result_q <= '{read_color: '0, modified: cmd_i.flag, oor: 1'b0};
              end
              default: begin
                done_q   <= 1'b1;
                result_q <= '{read_color: '0, modified: flag_q, oor: cmd_i.oor};
              end
            endcase
          end
        end
        ST_DRAW: begin
          step_q <= step_q + 2'd1;
          if (!dbl_q || step_q == 2'd3) begin
            flag_q   <= 1'b1;
            done_q   <= 1'b1;
            result_q <= '{read_color: '0, modified: 1'b1, oor: 1'b0};
            state_q  <= ST_IDLE;
          end
        end
        ST_READ: begin
          done_q   <= 1'b1;
          result_q <= '{read_color: rd_q, modified: flag_q, oor: 1'b0};
          state_q  <= ST_IDLE;
        end
        ST_FILL: begin
          ptr_q <= ptr_q + AW'(1);
          if (ptr_q == LastAddr) begin
            flag_q   <= 1'b1;
            done_q   <= 1'b1;
            result_q <= '{read_color: '0, modified: 1'b1, oor: 1'b0};
            state_q  <= ST_IDLE;
          end
        end
        ST_RECT: begin
          if (cx_q + CoordW'(1) == x1_q) begin
            // wrap to the next row
            cx_q  <= x0_q;
            cy_q  <= cy_q + CoordW'(1);
            row_q <= row_q + RowStep;
            if (cy_q + CoordW'(1) == y1_q) begin
              flag_q   <= 1'b1;
              done_q   <= 1'b1;
              result_q <= '{read_color: '0, modified: 1'b1, oor: 1'b0};
              state_q  <= ST_IDLE;
            end
          end else begin
            cx_q <= cx_q + CoordW'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ src/scaled_pixel_framebuffer.sv @@
`timescale 1ns / 1ps
// Scaled pixel frame store: RGB565 store for an LED panel with 2x doubling.
// Depends on spf_pkg, spf_front, spf_cmd_fifo and spf_back.
//
// Usage:
//   Command channel: a word is taken at a rising edge with start high and
//   busy low. The front classifies it and queues it (two entries); busy is
//   high while the queue is full or the store is being zeroed.
//   Result channel: done_o is high for one cycle with read_color_o,
//   modified_now_o and out_of_range_o; the receiver cannot stall it.
//   Configuration: cfg_we_i, cfg_index_i, cfg_wdata_i write a register at
//   once; write only while the block is idle.
// Execution (from queue head to done_o, paced by the single store port):
//   flag, dropped or invalid words are answered straight from idle; a read
//   passes through the read state; a draw makes one store write at scale
//   one and four store writes at scale two; clear all writes every store
//   entry; clear rectangle writes its clipped area. Words are queued first.
// Reset: registers return to 64, 32, 1, 0 and the modified flag to one;
//   the store is then zeroed entry by entry with busy high.
module scaled_pixel_framebuffer #(
  parameter int MAX_WIDTH  = spf_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT = spf_pkg::MaxHeightDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [2:0]  action_i,
  input  logic [5:0]  pos_x_i,
  input  logic [4:0]  pos_y_i,
  input  logic [5:0]  origin_x_i,
  input  logic [4:0]  origin_y_i,
  input  logic [6:0]  rect_width_i,
  input  logic [5:0]  rect_height_i,
  input  logic [15:0] pixel_color_i,
  input  logic        flag_value_i,
  output logic [15:0] read_color_o,
  output logic        modified_now_o,
  output logic        out_of_range_o
);
  import spf_pkg::*;

  cmd_t              front_cmd, head_cmd;
  result_t           result;
  logic [ColorW-1:0] bg_color;
  logic              accept, fifo_empty, fifo_full, pop, init_busy;

  assign busy   = fifo_full || init_busy;
  assign accept = start && !busy;

  spf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .action_i     (action_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .origin_x_i   (origin_x_i),
    .origin_y_i   (origin_y_i),
    .rect_width_i (rect_width_i),
    .rect_height_i(rect_height_i),
    .pixel_color_i(pixel_color_i),
    .flag_value_i (flag_value_i),
    .cmd_o        (front_cmd),
    .bg_color_o   (bg_color)
  );

  spf_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .empty_o(fifo_empty),
    .full_o (fifo_full)
  );

  spf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!fifo_empty),
    .cmd_i      (head_cmd),
    .bg_color_i (bg_color),
    .cmd_pop_o  (pop),
    .init_busy_o(init_busy),
    .done_o     (done_o),
    .result_o   (result)
  );

  assign read_color_o   = result.read_color;
  assign modified_now_o = result.modified;
  assign out_of_range_o = result.oor;

endmodule

@@ src/spf_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the scaled pixel frame store, bound to the top level.
// Depends on spf_pkg and scaled_pixel_framebuffer.
module spf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [15:0] read_color_o,
  input logic        out_of_range_o
);
  import spf_pkg::*;

  localparam int MaxPending = FifoDepth + 1;
  localparam int PendW      = $clog2(MaxPending + 2);

  logic [PendW-1:0] pending_q;
  logic             accept;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (accept && !done_o) begin
      pending_q <= pending_q + 1'b1;
    end else if (done_o && !accept && pending_q != '0) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // a result only ever answers a word already taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> pending_q != '0)
    else $error("result without an outstanding word");

  // the queue plus the executing word bound what can be outstanding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= PendW'(MaxPending))
    else $error("more words outstanding than the queue holds");

  // out-of-panel results carry no colour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_of_range_o |-> read_color_o == '0)
    else $error("out of range result with nonzero colour");

  // busy right after reset while the store is zeroed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> busy)
    else $error("not busy during the reset clearing pass");

endmodule

bind scaled_pixel_framebuffer spf_checker u_spf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .read_color_o  (read_color_o),
  .out_of_range_o(out_of_range_o)
);

@@ dv/scaled_pixel_framebuffer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for scaled_pixel_framebuffer: directed plan, then random bursts.
// Depends on spf_pkg and the scaled_pixel_framebuffer RTL; keeps its own shadow frame store.
module scaled_pixel_framebuffer_tb;
  import spf_pkg::*;

  localparam int FbW     = MaxWidthDefault;
  localparam int FbH     = MaxHeightDefault;
  localparam int FbDepth = FbW * FbH;

  // Action codes the block must ignore
  localparam logic [2:0] ACT_RSVD_A = 3'd6;
  localparam logic [2:0] ACT_RSVD_B = 3'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  pos_x;
    logic [4:0]  pos_y;
    logic [5:0]  origin_x;
    logic [4:0]  origin_y;
    logic [6:0]  rect_width;
    logic [5:0]  rect_height;
    logic [15:0] pixel_color;
    logic        flag_value;
  } fb_cmd_t;

  typedef struct {
    bit          is_setup;
    logic [15:0] set_w;
    logic [15:0] set_h;
    logic [15:0] set_s;
    logic [15:0] set_bg;
    fb_cmd_t     cmd;
    bit          typed;
    result_t     want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        done_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_wdata_i;
  logic [2:0]  action_i;
  logic [5:0]  pos_x_i;
  logic [4:0]  pos_y_i;
  logic [5:0]  origin_x_i;
  logic [4:0]  origin_y_i;
  logic [6:0]  rect_width_i;
  logic [5:0]  rect_height_i;
  logic [15:0] pixel_color_i;
  logic        flag_value_i;
  logic [15:0] read_color_o;
  logic        modified_now_o;
  logic        out_of_range_o;

  // Shadow of the block's state
  logic [15:0] shadow_fb [FbDepth];
  logic        shadow_modified;
  logic [6:0]  reg_width;
  logic [5:0]  reg_height;
  logic [1:0]  reg_scale;
  logic [15:0] reg_background;

  result_t     pending_results [$];
  int          drawn_spots [$];
  plan_row_t   plan [$];
  int          mismatch_count = 0;

  scaled_pixel_framebuffer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .done_o         (done_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (action_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .pixel_color_i  (pixel_color_i),
    .flag_value_i   (flag_value_i),
    .read_color_o   (read_color_o),
    .modified_now_o (modified_now_o),
    .out_of_range_o (out_of_range_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned panel_w();
    int unsigned w;
    w = reg_width;
    if (w < 1) w = 1;
    if (w > FbW) w = FbW;
    return w;
  endfunction

  function automatic int unsigned panel_h();
    int unsigned h;
    h = reg_height;
    if (h < 1) h = 1;
    if (h > FbH) h = FbH;
    return h;
  endfunction

  function automatic int unsigned pixel_span();
    return (reg_scale == 2'd2) ? 2 : 1;
  endfunction

  // Apply one word to the shadow store and return the result it must produce.
  function automatic result_t predict_pixel_result(fb_cmd_t c);
    result_t     r;
    int unsigned s, w, h, x0, y0, xe, ye, dx, dy, cx, cy;
    r = '0;
    s = pixel_span();
    w = panel_w();
    h = panel_h();
    case (c.action)
      ACT_DRAW, ACT_DRAW_AT: begin
        x0 = c.pos_x * s;
        y0 = c.pos_y * s;
        if (c.action == ACT_DRAW_AT) begin
          x0 += c.origin_x;
          y0 += c.origin_y;
        end
        // Drop the whole square if any pixel of it is off the panel
        if (x0 + s > w || y0 + s > h) begin
          r.oor = 1'b1;
        end else begin
          for (dy = 0; dy < s; dy++)
            for (dx = 0; dx < s; dx++)
              shadow_fb[(y0 + dy) * FbW + x0 + dx] = c.pixel_color;
          shadow_modified = 1'b1;
          drawn_spots.push_back(x0 * 256 + y0);
          if (drawn_spots.size() > 16) void'(drawn_spots.pop_front());
        end
      end
      ACT_CLEAR_ALL: begin
        foreach (shadow_fb[i]) shadow_fb[i] = reg_background;
        shadow_modified = 1'b1;
      end
      ACT_CLEAR_RECT: begin
        xe = c.origin_x + c.rect_width;
        ye = c.origin_y + c.rect_height;
        if (xe > w) xe = w;
        if (ye > h) ye = h;
        for (cy = c.origin_y; cy < ye; cy++)
          for (cx = c.origin_x; cx < xe; cx++)
            shadow_fb[cy * FbW + cx] = reg_background;
        shadow_modified = 1'b1;
      end
      ACT_READ: begin
        if (c.pos_x < w && c.pos_y < h) r.read_color = shadow_fb[c.pos_y * FbW + c.pos_x];
        else r.oor = 1'b1;
      end
      ACT_SET_FLAG: shadow_modified = c.flag_value;
      default: ;
    endcase
    r.modified = shadow_modified;
    return r;
  endfunction

  function automatic fb_cmd_t word_of(logic [2:0] act, int px, int py, int ox, int oy,
                                      int rw, int rh, int color, bit fl);
    fb_cmd_t c;
    c.action      = act;
    c.pos_x       = 6'(px);
    c.pos_y       = 5'(py);
    c.origin_x    = 6'(ox);
    c.origin_y    = 5'(oy);
    c.rect_width  = 7'(rw);
    c.rect_height = 6'(rh);
    c.pixel_color = 16'(color);
    c.flag_value  = fl;
    return c;
  endfunction

  function automatic result_t outcome(int color, bit mod, bit oor);
    result_t r;
    r.read_color = 16'(color);
    r.modified   = mod;
    r.oor        = oor;
    return r;
  endfunction

  task automatic add_step(input fb_cmd_t c, input bit typed, input result_t want);
    plan_row_t row;
    row = '{default: '0};
    row.cmd   = c;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endtask

  task automatic add_setup(input int w, input int h, input int s, input int bg);
    plan_row_t row;
    row = '{default: '0};
    row.is_setup = 1'b1;
    row.set_w    = 16'(w);
    row.set_h    = 16'(h);
    row.set_s    = 16'(s);
    row.set_bg   = 16'(bg);
    plan.push_back(row);
  endtask

  // Random word, mostly shaped to land on the current panel.
  function automatic fb_cmd_t random_word();
    fb_cmd_t     c;
    int unsigned roll, lw, lh, spot;
    c = fb_cmd_t'({$urandom, $urandom});
    lw = panel_w() / pixel_span();
    lh = panel_h() / pixel_span();
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      c.action = ACT_DRAW;
      if ($urandom_range(0, 4) != 0) begin
        c.pos_x = 6'($urandom_range(0, lw));
        c.pos_y = 5'($urandom_range(0, lh));
      end
    end else if (roll < 50) begin
      c.action = ACT_DRAW_AT;
      if ($urandom_range(0, 4) != 0) begin
        c.pos_x    = 6'($urandom_range(0, lw / 2));
        c.pos_y    = 5'($urandom_range(0, lh / 2));
        c.origin_x = 6'($urandom_range(0, panel_w() / 2));
        c.origin_y = 5'($urandom_range(0, panel_h() / 2));
      end
    end else if (roll < 75) begin
      c.action = ACT_READ;
      if (drawn_spots.size() > 0 && $urandom_range(0, 1) == 1) begin
        spot    = drawn_spots[$urandom_range(0, drawn_spots.size() - 1)];
        c.pos_x = 6'(spot / 256 + $urandom_range(0, 1));
        c.pos_y = 5'(spot % 256 + $urandom_range(0, 1));
      end else if ($urandom_range(0, 3) != 0) begin
        c.pos_x = 6'($urandom_range(0, panel_w()));
        c.pos_y = 5'($urandom_range(0, panel_h()));
      end
    end else if (roll < 85) begin
      c.action = ACT_SET_FLAG;
    end else if (roll < 93) begin
      c.action = ACT_CLEAR_RECT;
      // Keep most rectangles small; a clear walks its whole clipped area
      if ($urandom_range(0, 9) != 0) begin
        c.origin_x    = 6'($urandom_range(0, panel_w()));
        c.origin_y    = 5'($urandom_range(0, panel_h()));
        c.rect_width  = 7'($urandom_range(0, 8));
        c.rect_height = 6'($urandom_range(0, 8));
      end
    end else if (roll < 94) begin
      c.action = ACT_CLEAR_ALL;
    end else if (roll < 97) begin
      c.action = 3'($urandom_range(ACT_RSVD_A, ACT_RSVD_B));
    end else if (c.action == ACT_CLEAR_ALL) begin
      c.action = ACT_READ;
    end
    return c;
  endfunction

  // Present a word and hold it until the block takes it.
  task automatic send_word(input fb_cmd_t c, input bit typed, input result_t want);
    result_t got;
    action_i      <= c.action;
    pos_x_i       <= c.pos_x;
    pos_y_i       <= c.pos_y;
    origin_x_i    <= c.origin_x;
    origin_y_i    <= c.origin_y;
    rect_width_i  <= c.rect_width;
    rect_height_i <= c.rect_height;
    pixel_color_i <= c.pixel_color;
    flag_value_i  <= c.flag_value;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy);
    got = predict_pixel_result(c);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop start and wait until every outstanding word has answered.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0 || busy);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_panel_setup(input logic [15:0] w, h, s, bg);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PANEL_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_index_i <= CFG_PANEL_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_index_i <= CFG_PIXEL_SCALE;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_index_i <= CFG_BACKGROUND;
    cfg_wdata_i <= bg;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    reg_width      = w[6:0];
    reg_height     = h[5:0];
    reg_scale      = s[1:0];
    reg_background = bg;
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no word outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (read_color_o !== want.read_color) begin
          $error("read_color: expected %h, got %h", want.read_color, read_color_o);
          mismatch_count++;
        end
        if (modified_now_o !== want.modified) begin
          $error("modified_now: expected %b, got %b", want.modified, modified_now_o);
          mismatch_count++;
        end
        if (out_of_range_o !== want.oor) begin
          $error("out_of_range: expected %b, got %b", want.oor, out_of_range_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("scaled_pixel_framebuffer regression: fail");
    $finish;
  end

  initial begin
    int          sent, burst;
    logic [15:0] nw, nh, ns, nbg;
    rst_ni        = 1'b0;
    start         = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_PANEL_WIDTH;
    cfg_wdata_i   = '0;
    action_i      = ACT_DRAW;
    pos_x_i       = '0;
    pos_y_i       = '0;
    origin_x_i    = '0;
    origin_y_i    = '0;
    rect_width_i  = '0;
    rect_height_i = '0;
    pixel_color_i = '0;
    flag_value_i  = 1'b0;
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    shadow_modified = 1'b1;
    reg_width       = 7'd64;
    reg_height      = 6'd32;
    reg_scale       = 2'd1;
    reg_background  = '0;

    // Reset panel: 64 x 32, scale one, black background, flag set
    add_step(word_of(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, outcome(0, 1, 0));
    add_step(word_of(ACT_SET_FLAG, 0, 0, 0, 0, 0, 0, 0, 0), 1, outcome(0, 0, 0));
    add_step(word_of(ACT_DRAW, 0, 0, 0, 0, 0, 0, 'hFFFF, 0), 1, outcome(0, 1, 0));
    add_step(word_of(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, outcome('hFFFF, 1, 0));
    add_step(word_of(ACT_SET_FLAG, 0, 0, 0, 0, 0, 0, 0, 0), 1, outcome(0, 0, 0));
    // Off the right edge: dropped, flag left clear
    add_step(word_of(ACT_DRAW_AT, 63, 31, 1, 0, 0, 0, 'h1234, 1), 1, outcome(0, 0, 1));
    add_step(word_of(ACT_DRAW_AT, 0, 0, 63, 31, 0, 0, 'h5555, 0), 1, outcome(0, 1, 0));
    add_step(word_of(ACT_READ, 63, 31, 0, 0, 0, 0, 0, 0), 1, outcome('h5555, 1, 0));
    add_step(word_of(ACT_RSVD_A, 0, 0, 0, 0, 0, 0, 0, 0), 1, outcome(0, 1, 0));
    add_step(word_of(ACT_RSVD_B, 63, 31, 63, 31, 127, 63, 'hFFFF, 1), 1, outcome(0, 1, 0));
    add_step(word_of(ACT_SET_FLAG, 0, 0, 0, 0, 0, 0, 0, 0), 1, outcome(0, 0, 0));
    // Oversized rectangle clipped to the corner pixel
    add_step(word_of(ACT_CLEAR_RECT, 0, 0, 63, 31, 127, 63, 0, 0), 1, outcome(0, 1, 0));
    add_step(word_of(ACT_READ, 63, 31, 0, 0, 0, 0, 0, 0), 1, outcome(0, 1, 0));
    add_setup(10, 5, 2, 'hF81F);
    add_step(word_of(ACT_DRAW, 4, 1, 0, 0, 0, 0, 'h1234, 0), 0, '0);
    add_step(word_of(ACT_DRAW, 5, 0, 0, 0, 0, 0, 'h4321, 0), 0, '0);
    add_step(word_of(ACT_DRAW_AT, 0, 0, 8, 3, 0, 0, 'h0F0F, 0), 0, '0);
    add_step(word_of(ACT_READ, 9, 4, 0, 0, 0, 0, 0, 0), 0, '0);
    add_step(word_of(ACT_READ, 10, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_step(word_of(ACT_SET_FLAG, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_step(word_of(ACT_CLEAR_RECT, 0, 0, 2, 2, 0, 0, 0, 0), 0, '0);
    add_step(word_of(ACT_CLEAR_ALL, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_step(word_of(ACT_READ, 63, 31, 0, 0, 0, 0, 0, 0), 0, '0);
    // Zero size clamps to one pixel, scale three acts as one
    add_setup(0, 0, 3, 'h0000);
    add_step(word_of(ACT_DRAW, 0, 0, 0, 0, 0, 0, 'hABCD, 0), 0, '0);
    add_step(word_of(ACT_DRAW, 1, 0, 0, 0, 0, 0, 'hABCD, 0), 0, '0);
    add_step(word_of(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_setup(127, 63, 0, 'hFFFF);
    add_step(word_of(ACT_DRAW, 63, 31, 0, 0, 0, 0, 'h0F0F, 0), 0, '0);
    add_step(word_of(ACT_CLEAR_RECT, 0, 0, 0, 0, 64, 32, 0, 0), 0, '0);
    add_step(word_of(ACT_READ, 40, 20, 0, 0, 0, 0, 0, 0), 0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_setup) begin
        settle();
        load_panel_setup(plan[i].set_w, plan[i].set_h, plan[i].set_s, plan[i].set_bg);
      end else begin
        send_word(plan[i].cmd, plan[i].typed, plan[i].want);
      end
    end

    for (int stage = 0; stage < 6; stage++) begin
      if (stage == 0) begin
        nw = 16'd64;
        nh = 16'd32;
        ns = 16'd2;
      end else begin
        case ($urandom_range(0, 5))
          0:       nw = 16'd1;
          1:       nw = 16'd2;
          2:       nw = 16'd64;
          3:       nw = 16'($urandom_range(0, 127));
          default: nw = 16'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 5))
          0:       nh = 16'd1;
          1:       nh = 16'd32;
          2:       nh = 16'($urandom_range(0, 63));
          default: nh = 16'($urandom_range(1, 32));
        endcase
        ns = ($urandom_range(0, 1) == 1) ? 16'd2 : 16'($urandom_range(0, 3));
        // Junk in the unused upper bits now and then
        if ($urandom_range(0, 3) == 0) begin
          nw[15:7] = 9'($urandom);
          nh[15:6] = 10'($urandom);
          ns[15:2] = 14'($urandom);
        end
      end
      nbg = 16'($urandom);
      settle();
      load_panel_setup(nw, nh, ns, nbg);
      sent = 0;
      while (sent < 200) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst && sent < 200; b++) begin
          send_word(random_word(), 0, '0);
          sent++;
          if (stage == 2 && sent == 100) settle();
        end
        // Stage three runs with no gaps at all
        if (stage != 3 && $urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
      end
    end

    settle();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("scaled_pixel_framebuffer regression: pass");
    end else begin
      $display("scaled_pixel_framebuffer regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/spf_pkg.sv
src/spf_front.sv
src/spf_cmd_fifo.sv
src/spf_back.sv
src/scaled_pixel_framebuffer.sv
src/spf_checker.sv
dv/scaled_pixel_framebuffer_tb.sv
